[rtl/ppfm_pkg.sv]
package ppfm_pkg;

	// fixed widths of the register and result fields
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int FREQ_W     = 28;
	localparam int MICROS_W   = 20;

	localparam int DEF_TIME_WIDTH    = 32;
	localparam int DEF_COUNT_WIDTH   = 24;
	localparam int DEF_FRACTION_BITS = 8;

	localparam logic [CFG_W-1:0]  MICROS_PER_SECOND = 32'd1000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX          = '1;

	localparam logic [CFG_W-1:0] RST_SAMPLE_WINDOW = 32'd1000000;
	localparam logic [CFG_W-1:0] RST_MIN_PERIOD    = 32'd100;
	localparam logic [CFG_W-1:0] RST_MAX_PERIOD    = 32'd500000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_WINDOW = 2'd0,
		REG_MIN_PERIOD    = 2'd1,
		REG_MAX_PERIOD    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_EDGE = 2'd0,
		CMD_POLL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic start;
		logic clear;
	} ppfm_acc_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic set_ready;
	} ppfm_acc_stat_t;

endpackage

[rtl/ppfm_divider.sv]
module ppfm_divider import ppfm_pkg::*; #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	// one restoring step: bring down the next dividend bit and try a subtract
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				if (!diff[DVS_W]) begin
					rem_q <= diff[DVS_W-1:0];
					quo_q <= {quo_q[DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DVS_W-1:0];
					quo_q <= {quo_q[DVD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/ppfm_accum.sv]
module ppfm_accum import ppfm_pkg::*; #(
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppfm_acc_ctl_t          ctl,
	input  logic [TIME_WIDTH-1:0]  timestamp,
	input  logic [CFG_W-1:0]       sample_window,
	input  logic [CFG_W-1:0]       min_period,
	input  logic [CFG_W-1:0]       max_period,
	output ppfm_acc_stat_t         stat,
	output logic [TIME_WIDTH-1:0]  period_sum,
	output logic [COUNT_WIDTH-1:0] period_count
);

	localparam int BIT_W = $clog2(TIME_WIDTH);
	localparam int EXT_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	logic                   busy_q, done_q, set_ready_q;
	logic [BIT_W-1:0]       bit_q;
	logic [TIME_WIDTH-1:0]  ts_q, last_q, sum_q, cand_q;
	logic [TIME_WIDTH-1:0]  min_q, max_q, win_q;
	logic                   min_hi_q, max_hi_q, win_hi_q;
	logic                   borrow_q, carry_q, gt_min_q, lt_max_q, gt_win_q, win_ones_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [EXT_W-1:0] min_ext, max_ext, win_ext;

	assign min_ext = EXT_W'(min_period);
	assign max_ext = EXT_W'(max_period);
	assign win_ext = EXT_W'(sample_window);

	// serial step, lsb first
	logic d, borrow_n, s, carry_n, gt_min_n, lt_max_n, gt_win_n;
	logic last_bit, hit, over;
	logic [TIME_WIDTH-1:0] cand_n;

	always_comb begin
		d        = ts_q[0] ^ last_q[0] ^ borrow_q;
		borrow_n = (~ts_q[0] & last_q[0]) | (~(ts_q[0] ^ last_q[0]) & borrow_q);
		s        = sum_q[0] ^ d ^ carry_q;
		carry_n  = (sum_q[0] & d) | (carry_q & (sum_q[0] ^ d));
		gt_min_n = (d & ~min_q[0]) | (~(d ^ min_q[0]) & gt_min_q);
		lt_max_n = (~d & max_q[0]) | (~(d ^ max_q[0]) & lt_max_q);
		gt_win_n = (s & ~win_q[0]) | (~(s ^ win_q[0]) & gt_win_q);
		cand_n   = {s, cand_q[TIME_WIDTH-1:1]};
		last_bit = (bit_q == BIT_W'(TIME_WIDTH - 1));
		hit      = !min_hi_q && gt_min_n && (max_hi_q || lt_max_n);
		// saturated sum is all ones, above the window unless the window is all ones too
		over     = !win_hi_q && (carry_n ? !(win_ones_q & win_q[0]) : gt_win_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			set_ready_q <= 1'b0;
			bit_q       <= '0;
			ts_q        <= '0;
			last_q      <= '0;
			sum_q       <= '0;
			cand_q      <= '0;
			min_q       <= '0;
			max_q       <= '0;
			win_q       <= '0;
			min_hi_q    <= 1'b0;
			max_hi_q    <= 1'b0;
			win_hi_q    <= 1'b0;
			borrow_q    <= 1'b0;
			carry_q     <= 1'b0;
			gt_min_q    <= 1'b0;
			lt_max_q    <= 1'b0;
			gt_win_q    <= 1'b0;
			win_ones_q  <= 1'b1;
			count_q     <= '0;
		end else begin
			done_q      <= !ctl.clear && !ctl.start && busy_q && last_bit;
			set_ready_q <= !ctl.clear && !ctl.start && busy_q && last_bit && hit && over;
			if (ctl.clear) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (ctl.start) begin
				busy_q     <= 1'b1;
				bit_q      <= '0;
				ts_q       <= timestamp;
				min_q      <= min_ext[TIME_WIDTH-1:0];
				max_q      <= max_ext[TIME_WIDTH-1:0];
				win_q      <= win_ext[TIME_WIDTH-1:0];
				min_hi_q   <= |(min_ext >> TIME_WIDTH);
				max_hi_q   <= |(max_ext >> TIME_WIDTH);
				win_hi_q   <= |(win_ext >> TIME_WIDTH);
				borrow_q   <= 1'b0;
				carry_q    <= 1'b0;
				gt_min_q   <= 1'b0;
				lt_max_q   <= 1'b0;
				gt_win_q   <= 1'b0;
				win_ones_q <= 1'b1;
			end else if (busy_q) begin
				bit_q      <= bit_q + 1'b1;
				ts_q       <= {1'b0, ts_q[TIME_WIDTH-1:1]};
				last_q     <= {ts_q[0], last_q[TIME_WIDTH-1:1]};
				min_q      <= {1'b0, min_q[TIME_WIDTH-1:1]};
				max_q      <= {1'b0, max_q[TIME_WIDTH-1:1]};
				win_q      <= {1'b0, win_q[TIME_WIDTH-1:1]};
				cand_q     <= cand_n;
				borrow_q   <= borrow_n;
				carry_q    <= carry_n;
				gt_min_q   <= gt_min_n;
				lt_max_q   <= lt_max_n;
				gt_win_q   <= gt_win_n;
				win_ones_q <= win_ones_q & win_q[0];
				if (last_bit) begin
					busy_q <= 1'b0;
					if (hit) begin
						sum_q <= carry_n ? '1 : cand_n;
						if (count_q != '1)
							count_q <= count_q + 1'b1;
					end else begin
						sum_q <= {sum_q[0], sum_q[TIME_WIDTH-1:1]};
					end
				end else begin
					// rotate so the old sum is back in place after a full pass
					sum_q <= {sum_q[0], sum_q[TIME_WIDTH-1:1]};
				end
			end
		end
	end

	assign stat.busy      = busy_q;
	assign stat.done      = done_q;
	assign stat.set_ready = set_ready_q;
	assign period_sum     = sum_q;
	assign period_count   = count_q;

endmodule

[rtl/pulse_period_frequency_meter_top.sv]
// edge transaction: a bit-serial subtract/compare/add pass through the accumulator
// poll and reserved transactions, and a read with no periods counted, go straight to ST_FIN
// read: two radix-2 divisions on the one shared divider, average period then frequency
// one transaction at a time; a finished result waits in the output register
// arst_n clears all state; registers return to 1000000 / 100 / 500000
module pulse_period_frequency_meter_top import ppfm_pkg::*; #(
	parameter int TIME_WIDTH    = DEF_TIME_WIDTH,
	parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// input transactions
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic [TIME_WIDTH-1:0] timestamp_us,
	// result transactions
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sample_ready,
	output logic [FREQ_W-1:0]     frequency_q8
);

	// dividend of the frequency division: 1e6 scaled by the fraction bits
	localparam int NUM_W = MICROS_W + FRACTION_BITS;
	localparam int DVD_W = (TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W;
	localparam int DVS_W = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
	localparam int CMP_W = (DVD_W > FREQ_W) ? DVD_W : FREQ_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV_AVG,
		ST_DIV_FREQ,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] sample_window_q, min_period_q, max_period_q;

	logic ready_flag_q;
	logic res_ready_q;
	logic [FREQ_W-1:0] res_freq_q;
	logic out_valid_q;
	logic out_ready_q;
	logic [FREQ_W-1:0] out_freq_q;

	logic in_accept;
	cmd_t cmd_in;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cmd_in    = cmd_t'(cmd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_window_q <= RST_SAMPLE_WINDOW;
			min_period_q    <= RST_MIN_PERIOD;
			max_period_q    <= RST_MAX_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SAMPLE_WINDOW: sample_window_q <= cfg_data;
				REG_MIN_PERIOD:    min_period_q    <= cfg_data;
				REG_MAX_PERIOD:    max_period_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulator: last edge time, period sum and count
	ppfm_acc_ctl_t          acc_ctl;
	ppfm_acc_stat_t         acc_stat;
	logic [TIME_WIDTH-1:0]  period_sum;
	logic [COUNT_WIDTH-1:0] period_count;

	// shared divider: average period first, then the reciprocal
	logic             div_start, div_busy, div_done;
	logic [DVD_W-1:0] div_dividend, div_quotient;
	logic [DVS_W-1:0] div_divisor;
	logic [CMP_W-1:0] freq_ext;

	always_comb begin
		acc_ctl.start = in_accept && (cmd_in == CMD_EDGE);
		acc_ctl.clear = (state_q == ST_DIV_AVG) && div_done;
		div_start     = (in_accept && (cmd_in == CMD_READ) && (period_count != '0))
		                || ((state_q == ST_DIV_AVG) && div_done);
		if (state_q == ST_IDLE) begin
			div_dividend = DVD_W'(period_sum);
			div_divisor  = DVS_W'(period_count);
		end else begin
			div_dividend = DVD_W'(MICROS_PER_SECOND) << FRACTION_BITS;
			// average fits the time width because the count is at least one
			div_divisor  = DVS_W'(div_quotient[TIME_WIDTH-1:0]);
		end
		// a zero average divides to all ones and so saturates here as well
		freq_ext = CMP_W'(div_quotient);
	end

	ppfm_accum #(
		.TIME_WIDTH  (TIME_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (acc_ctl),
		.timestamp     (timestamp_us),
		.sample_window (sample_window_q),
		.min_period    (min_period_q),
		.max_period    (max_period_q),
		.stat          (acc_stat),
		.period_sum    (period_sum),
		.period_count  (period_count)
	);

	ppfm_divider #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// control sequence and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ready_flag_q <= 1'b0;
			res_ready_q  <= 1'b0;
			res_freq_q   <= '0;
			out_valid_q  <= 1'b0;
			out_ready_q  <= 1'b0;
			out_freq_q   <= '0;
		end else begin
			// result taken by the consumer
			if (out_valid_q && !out_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						res_ready_q <= ready_flag_q;
						res_freq_q  <= '0;
						case (cmd_in)
							CMD_EDGE: state_q <= ST_EDGE;
							CMD_POLL: begin
								ready_flag_q <= 1'b0;
								state_q      <= ST_FIN;
							end
							CMD_READ: begin
								// nothing counted: frequency stays zero
								state_q <= (period_count != '0) ? ST_DIV_AVG : ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_EDGE: begin
					if (acc_stat.done) begin
						// edge reports the flag after its own update
						if (acc_stat.set_ready)
							ready_flag_q <= 1'b1;
						res_ready_q <= ready_flag_q | acc_stat.set_ready;
						state_q     <= ST_FIN;
					end
				end
				ST_DIV_AVG: begin
					if (div_done)
						state_q <= ST_DIV_FREQ;
				end
				ST_DIV_FREQ: begin
					if (div_done) begin
						res_freq_q <= (freq_ext > CMP_W'(FREQ_MAX)) ? FREQ_MAX
						              : freq_ext[FREQ_W-1:0];
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hand over once the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_ready_q <= res_ready_q;
						out_freq_q  <= res_freq_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_ready = out_ready_q;
	assign frequency_q8 = out_freq_q;

	// a new transaction only starts with both serial units at rest
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (!acc_stat.busy && !div_busy))
		else $error("transaction accepted while a serial unit is busy");

	// divider results only arrive while a read is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_AVG || state_q == ST_DIV_FREQ))
		else $error("divider finished outside a read");

	// the ready flag only rises from a finished edge update
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_flag_q) |-> $past(acc_stat.done && acc_stat.set_ready))
		else $error("ready flag set without an edge update");

	// accumulators are cleared only when the average division of a read with periods counted ends
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctl.clear |=> (period_count == '0 && period_sum == '0))
		else $error("accumulators not cleared after read");

endmodule
